[sv/wmc_pkg.sv]
// shared types, constants and helpers for the water heater mode controller
`default_nettype none
package wmc_pkg;

  localparam int unsigned BAND_W   = 5;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned TEMP_W   = 8;
  localparam int unsigned IDLE_W   = 16;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BAND_W-1:0] BAND_RST  = BAND_W'(5);
  localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(5);
  localparam logic [TEMP_W-1:0] UPPER_RST = TEMP_W'(70);
  localparam logic [TEMP_W-1:0] LOWER_RST = TEMP_W'(40);
  localparam logic [IDLE_W-1:0] IDLE_RST  = IDLE_W'(50);
  localparam logic [TEMP_W-1:0] TARGET_RST = TEMP_W'(60);

  // mode codes as seen on the result channel
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OPER   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESET  = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND  = 3'd0,
    CFG_STEP  = 3'd1,
    CFG_UPPER = 3'd2,
    CFG_LOWER = 3'd3,
    CFG_IDLE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_OFF    = 5'b00001,
    ST_OPER   = 5'b00010,
    ST_NORMAL = 5'b00100,
    ST_SET    = 5'b01000,
    ST_RESET  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [STEP_W-1:0] step;
    logic [TEMP_W-1:0] upper;
    logic [TEMP_W-1:0] lower;
    logic [IDLE_W-1:0] idle_max;
  } cfg_t;

  typedef struct packed {
    logic               heater_on;
    logic               cooler_on;
    logic               display_on;
    logic               heat_blink;
    logic               set_blink;
    logic [DIGIT_W-1:0] units;
    logic [DIGIT_W-1:0] tens;
    logic               save;
    logic [TEMP_W-1:0]  target;
    logic [MODE_W-1:0]  mode;
  } res_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] units;
    logic [DIGIT_W-1:0] tens;
  } digits_t;

  // split v mod 100 into tens and units digits, divide by ten via reciprocal
  function automatic digits_t split_digits(input logic [TEMP_W-1:0] v);
    logic [18:0]       prod;
    logic [4:0]        q;
    logic [4:0]        qt;
    logic [7:0]        q10;
    logic [7:0]        rem;
    digits_t           d;
    prod = 19'(v) * 19'd205;
    q    = prod[15:11];
    q10  = 8'({q, 3'b000}) + 8'({q, 1'b0});
    rem  = v - q10;
    if (q >= 5'd20) begin
      qt = q - 5'd20;
    end else if (q >= 5'd10) begin
      qt = q - 5'd10;
    end else begin
      qt = q;
    end
    d.units = rem[DIGIT_W-1:0];
    d.tens  = qt[DIGIT_W-1:0];
    return d;
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input state_t s);
    logic [MODE_W-1:0] c;
    case (s)
      ST_OFF:    c = MODE_OFF;
      ST_OPER:   c = MODE_OPER;
      ST_NORMAL: c = MODE_NORMAL;
      ST_SET:    c = MODE_SET;
      ST_RESET:  c = MODE_RESET;
      default:   c = MODE_OFF;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/wmc_cfg.sv]
// configuration register file of the water heater mode controller
`default_nettype none
module wmc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [wmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output wmc_pkg::cfg_t                         cfg
);
  import wmc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band     <= BAND_RST;
      cfg_r.step     <= STEP_RST;
      cfg_r.upper    <= UPPER_RST;
      cfg_r.lower    <= LOWER_RST;
      cfg_r.idle_max <= IDLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BAND:  cfg_r.band     <= cfg_wdata[BAND_W-1:0];
        CFG_STEP:  cfg_r.step     <= cfg_wdata[STEP_W-1:0];
        CFG_UPPER: cfg_r.upper    <= cfg_wdata[TEMP_W-1:0];
        CFG_LOWER: cfg_r.lower    <= cfg_wdata[TEMP_W-1:0];
        CFG_IDLE:  cfg_r.idle_max <= cfg_wdata[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[sv/wmc_core.sv]
// mode machine, thermostat and setpoint logic, one item per accepted cycle
`default_nettype none
module wmc_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_ok,
  input  wire logic                        pwr,
  input  wire logic                        up,
  input  wire logic                        down,
  input  wire logic [wmc_pkg::TEMP_W-1:0]  temp,
  input  wire wmc_pkg::cfg_t               cfg,
  output wmc_pkg::res_t                    res
);
  import wmc_pkg::*;

  state_t              st_r, st_nxt;
  logic                prev_set_r, prev_set_nxt;
  logic [TEMP_W-1:0]   target_r, target_nxt;
  logic [TEMP_W-1:0]   latched_r, latched_nxt;
  logic [IDLE_W-1:0]   idle_r, idle_nxt;
  logic                heater_r, heater_nxt;
  logic                cooler_r, cooler_nxt;
  logic                disp_r, disp_nxt;
  logic                hblink_r, hblink_nxt;
  logic                sblink_r, sblink_nxt;
  logic [DIGIT_W-1:0]  units_r, units_nxt;
  logic [DIGIT_W-1:0]  tens_r, tens_nxt;
  logic                save_r, save_nxt;

  logic [TEMP_W:0]     temp_lo;
  logic [TEMP_W:0]     target_hi;
  logic [TEMP_W-1:0]   tgt_up;
  logic [TEMP_W-1:0]   tgt_dn;
  logic                up_ok;
  logic                dn_ok;
  logic [IDLE_W-1:0]   idle_cur;
  digits_t             dig_latched;
  digits_t             dig_target;

  assign temp_lo     = {1'b0, temp} + (TEMP_W+1)'(cfg.band);
  assign target_hi   = {1'b0, target_r} + (TEMP_W+1)'(cfg.band);
  assign up_ok       = up && (target_r <= cfg.upper);
  assign tgt_up      = up_ok ? target_r + TEMP_W'(cfg.step) : target_r;
  assign dn_ok       = down && (tgt_up >= cfg.lower);
  assign tgt_dn      = dn_ok ? tgt_up - TEMP_W'(cfg.step) : tgt_up;
  assign idle_cur    = (up_ok || dn_ok) ? '0 : idle_r;
  assign dig_latched = split_digits(latched_r);
  assign dig_target  = split_digits(target_r);

  always_comb begin
    st_nxt       = st_r;
    prev_set_nxt = prev_set_r;
    target_nxt   = target_r;
    latched_nxt  = latched_r;
    idle_nxt     = idle_r;
    heater_nxt   = heater_r;
    cooler_nxt   = cooler_r;
    disp_nxt     = disp_r;
    hblink_nxt   = hblink_r;
    sblink_nxt   = sblink_r;
    units_nxt    = units_r;
    tens_nxt     = tens_r;
    save_nxt     = 1'b0;
    case (st_r)
      ST_OFF: begin
        if (pwr) begin
          disp_nxt = 1'b1;
          st_nxt   = ST_OPER;
        end
      end
      ST_OPER: begin
        latched_nxt = temp;
        // hysteresis compares kept unsigned by moving the band to the other side
        if (temp_lo <= {1'b0, target_r}) begin
          heater_nxt = 1'b1;
          cooler_nxt = 1'b0;
          hblink_nxt = 1'b1;
        end else if ({1'b0, temp} >= target_hi) begin
          heater_nxt = 1'b0;
          cooler_nxt = 1'b1;
          hblink_nxt = 1'b0;
        end
        st_nxt = prev_set_r ? ST_SET : ST_NORMAL;
      end
      ST_NORMAL: begin
        prev_set_nxt = 1'b0;
        units_nxt    = dig_latched.units;
        tens_nxt     = dig_latched.tens;
        if (up || down) begin
          st_nxt = ST_SET;
        end else if (pwr) begin
          st_nxt = ST_RESET;
        end else begin
          st_nxt = ST_OPER;
        end
      end
      ST_SET: begin
        prev_set_nxt = 1'b1;
        units_nxt    = dig_target.units;
        tens_nxt     = dig_target.tens;
        target_nxt   = tgt_dn;
        if (idle_cur >= cfg.idle_max) begin
          idle_nxt   = '0;
          sblink_nxt = 1'b0;
          save_nxt   = 1'b1;
          st_nxt     = ST_NORMAL;
        end else begin
          idle_nxt   = idle_cur + IDLE_W'(1);
          sblink_nxt = 1'b1;
          st_nxt     = pwr ? ST_RESET : ST_OPER;
        end
      end
      default: begin
        heater_nxt = 1'b0;
        cooler_nxt = 1'b0;
        disp_nxt   = 1'b0;
        hblink_nxt = 1'b0;
        sblink_nxt = 1'b0;
        save_nxt   = 1'b1;
        st_nxt     = ST_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_OFF;
      prev_set_r <= 1'b0;
      target_r   <= TARGET_RST;
      latched_r  <= '0;
      idle_r     <= '0;
      heater_r   <= 1'b0;
      cooler_r   <= 1'b0;
      disp_r     <= 1'b0;
      hblink_r   <= 1'b0;
      sblink_r   <= 1'b0;
      units_r    <= '0;
      tens_r     <= '0;
      save_r     <= 1'b0;
    end else if (in_ok) begin
      st_r       <= st_nxt;
      prev_set_r <= prev_set_nxt;
      target_r   <= target_nxt;
      latched_r  <= latched_nxt;
      idle_r     <= idle_nxt;
      heater_r   <= heater_nxt;
      cooler_r   <= cooler_nxt;
      disp_r     <= disp_nxt;
      hblink_r   <= hblink_nxt;
      sblink_r   <= sblink_nxt;
      units_r    <= units_nxt;
      tens_r     <= tens_nxt;
      save_r     <= save_nxt;
    end
  end

  always_comb begin
    res.heater_on  = heater_r;
    res.cooler_on  = cooler_r;
    res.display_on = disp_r;
    res.heat_blink = hblink_r;
    res.set_blink  = sblink_r;
    res.units      = units_r;
    res.tens       = tens_r;
    res.save       = save_r;
    res.target     = target_r;
    res.mode       = mode_code(st_r);
  end

  a_no_heat_and_cool: assert property (@(posedge clk) disable iff (!rst_n)
    !(heater_r && cooler_r))
    else $error("heater and cooler driven together");

  a_reset_goes_off: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ok && st_r == ST_RESET) |=> (st_r == ST_OFF && save_r && !disp_r))
    else $error("reset mode did not return to off with a save");

  a_target_only_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ok && st_r == ST_SET) |=> $stable(target_r))
    else $error("target changed outside setpoint mode");

  a_save_source: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ok && save_nxt) |-> (st_r == ST_SET || st_r == ST_RESET))
    else $error("save raised outside setpoint or reset mode");

endmodule
`default_nettype wire

[sv/water_heater_mode_controller_top.sv]
// water heater mode controller top level: handshake, config and core
//
// usage:
//   input channel carries one task tick per item: three button levels and
//   the averaged water temperature; the result channel returns exactly one
//   item per tick with the drives, indicators, display digits, save strobe,
//   target and mode after that tick; config registers are written through
//   cfg_we / cfg_index / cfg_wdata by the user while the block is idle; the
//   block itself does not enforce this; unknown indexes are ignored
// latency: a result is valid the cycle after its item is accepted
// throughput: one item per cycle unless stalled; the state registers
//   double as the result register, so the next item is taken in the same
//   cycle the current result is taken
// stall: while out_stall holds a pending result, in_stall is raised and the
//   result stays unchanged
// reset: synchronous active-low rst_n puts the block in off mode, target 60,
//   all drives and indicators off, config registers to their defaults, and
//   no result pending
`default_nettype none
module water_heater_mode_controller_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic                              in_power_button,
  input  wire logic                              in_up_button,
  input  wire logic                              in_down_button,
  input  wire logic [wmc_pkg::TEMP_W-1:0]        in_measured_temp,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic                              out_heater_on,
  output      logic                              out_cooler_on,
  output      logic                              out_display_on,
  output      logic                              out_heat_indicator_blink,
  output      logic                              out_setpoint_blink,
  output      logic [wmc_pkg::DIGIT_W-1:0]       out_units_digit,
  output      logic [wmc_pkg::DIGIT_W-1:0]       out_tens_digit,
  output      logic                              out_save_strobe,
  output      logic [wmc_pkg::TEMP_W-1:0]        out_target_value,
  output      logic [wmc_pkg::MODE_W-1:0]        out_mode,
  input  wire logic                              cfg_we,
  input  wire logic [wmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wmc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wmc_pkg::*;

  cfg_t cfg;
  res_t res;
  logic in_ok;
  logic out_valid_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_ok    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ok) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  wmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wmc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ok (in_ok),
    .pwr   (in_power_button),
    .up    (in_up_button),
    .down  (in_down_button),
    .temp  (in_measured_temp),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid                = out_valid_r;
  assign out_heater_on            = res.heater_on;
  assign out_cooler_on            = res.cooler_on;
  assign out_display_on           = res.display_on;
  assign out_heat_indicator_blink = res.heat_blink;
  assign out_setpoint_blink       = res.set_blink;
  assign out_units_digit          = res.units;
  assign out_tens_digit           = res.tens;
  assign out_save_strobe          = res.save;
  assign out_target_value         = res.target;
  assign out_mode                 = res.mode;

endmodule
`default_nettype wire
